[sv/pspe_pkg.sv]
// pspe_pkg: shared types and constants for the palette sprite pixel expander
// no dependencies
`default_nettype none

package pspe_pkg;

	// item opcodes
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_PIXEL = 1'b1;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_W     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_H     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_OPACITY_MODE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_DISP_OPACITY = 3'd5;
	localparam int CFG_DATA_W = 16;

	localparam logic [6:0] OPACITY_FULL = 7'd100;

	// 4-bit opacity code to percent, op * 100 / 15 rounded down
	localparam logic [6:0] OPACITY_PCT [16] = '{
		7'd0,  7'd6,  7'd13, 7'd20, 7'd26, 7'd33, 7'd40, 7'd46,
		7'd53, 7'd60, 7'd66, 7'd73, 7'd80, 7'd86, 7'd93, 7'd100
	};

	// floor(p / 100) = (p * 5243) >> 19, exact for p <= 10000
	localparam logic [12:0] DIV100_RECIP = 13'd5243;
	localparam int DIV100_SHIFT = 19;

	typedef struct packed {
		logic        opcode;
		logic [3:0]  palette_slot;
		logic [15:0] palette_color;
		logic [7:0]  pixel_byte;
	} pspe_in_t;

	typedef struct packed {
		logic signed [15:0] pixel_x;
		logic signed [15:0] pixel_y;
		logic [15:0]        pixel_color;
		logic [6:0]         pixel_opacity;
		logic               last_pixel;
	} pspe_out_t;

	// current scan position handed from the walker to the pipeline
	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic               last;
	} pspe_pos_t;

endpackage

`default_nettype wire

[sv/pspe_palette_ram.sv]
// pspe_palette_ram: palette color memory, one write and one registered read port
// no package dependencies
`default_nettype none

module pspe_palette_ram #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [15:0]   wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [15:0]   rdata
);

	logic [15:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[sv/pspe_scan.sv]
// pspe_scan: row-major column and row counters, absolute coordinates
// depends on pspe_pkg
`default_nettype none

module pspe_scan
	import pspe_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               step,
	input  wire logic [7:0]         sprite_width,
	input  wire logic [7:0]         sprite_height,
	input  wire logic signed [15:0] origin_x,
	input  wire logic signed [15:0] origin_y,
	output pspe_pos_t               pos
);

	logic [7:0] col_q;
	logic [7:0] row_q;
	logic [7:0] w_eff;
	logic [7:0] h_eff;
	logic       last_col;
	logic       last_row;

	// zero geometry acts as one
	assign w_eff = (sprite_width == 8'd0) ? 8'd1 : sprite_width;
	assign h_eff = (sprite_height == 8'd0) ? 8'd1 : sprite_height;

	// at or past the end counts as the end
	assign last_col = ({1'b0, col_q} + 9'd1) >= {1'b0, w_eff};
	assign last_row = ({1'b0, row_q} + 9'd1) >= {1'b0, h_eff};

	assign pos.x    = origin_x + $signed({8'd0, col_q});
	assign pos.y    = origin_y + $signed({8'd0, row_q});
	assign pos.last = last_col && last_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (step) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? 8'd0 : row_q + 8'd1;
			end else begin
				col_q <= col_q + 8'd1;
			end
		end
	end

	a_wrap_to_origin: assert property (@(posedge clk) disable iff (!arst_n)
		(step && pos.last) |=> (col_q == 8'd0 && row_q == 8'd0))
		else $error("scan counters did not wrap after last pixel");

endmodule

`default_nettype wire

[sv/palette_sprite_pixel_expander.sv]
// palette_sprite_pixel_expander: top level, palettized sprite to pixel write commands
// depends on pspe_pkg, pspe_palette_ram, pspe_scan
//
//  channel  | signals                              | transfer moves
//  ---------+--------------------------------------+--------------------------------
//  item     | item_valid, item_ready, item         | palette load or one pixel byte
//  result   | result_valid, result_ready, result   | one pixel write command
//  cfg      | cfg_valid, cfg_ready, cfg_index/data | one register write
//
// one item per clock sustained while results are taken; a pixel result is
// registered in stage 1, where the palette memory read and opacity product land
// at the transfer edge, then in the output register, through the divide by 100,
// when stage 1 advances; load items produce no result and only write the palette memory
// arst_n resets the scan counters, configuration registers and pipeline valids; palette is unset
// a stalled result holds the output register, a second pixel waits in stage 1,
// and item_ready drops only when both are full
`default_nettype none

module palette_sprite_pixel_expander
	import pspe_pkg::*;
#(
	parameter int PALETTE_ENTRIES = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  item_valid,
	output logic                       item_ready,
	input  wire pspe_in_t              item,
	output logic                       result_valid,
	input  wire logic                  result_ready,
	output pspe_out_t                  result,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

	// configuration registers
	logic signed [15:0] origin_x_q;
	logic signed [15:0] origin_y_q;
	logic [7:0]         sprite_width_q;
	logic [7:0]         sprite_height_q;
	logic               opacity_mode_q;
	logic [6:0]         disp_opacity_q;

	// handshakes
	logic item_xfer;
	logic load_xfer;
	logic pixel_xfer;
	logic advance;

	// front end decode
	logic [3:0]  color_idx;
	logic [3:0]  op_code4;
	logic        slot_hit;
	logic        idx_hit;
	logic [6:0]  pct;
	logic [6:0]  disp_sat;
	logic [6:0]  scale;
	pspe_pos_t   pos;

	// stage 1
	logic               valid_s1;
	logic signed [15:0] x_s1;
	logic signed [15:0] y_s1;
	logic               last_s1;
	logic               hit_s1;
	logic [13:0]        prod_s1;
	logic [15:0]        ram_rdata;

	// output stage
	logic [25:0] recip_prod;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q      <= '0;
			origin_y_q      <= '0;
			sprite_width_q  <= 8'd1;
			sprite_height_q <= 8'd1;
			opacity_mode_q  <= 1'b0;
			disp_opacity_q  <= OPACITY_FULL;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ORIGIN_X:     origin_x_q      <= $signed(cfg_data);
				CFG_ORIGIN_Y:     origin_y_q      <= $signed(cfg_data);
				CFG_SPRITE_W:     sprite_width_q  <= cfg_data[7:0];
				CFG_SPRITE_H:     sprite_height_q <= cfg_data[7:0];
				CFG_OPACITY_MODE: opacity_mode_q  <= cfg_data[0];
				CFG_DISP_OPACITY: disp_opacity_q  <= cfg_data[6:0];
				default: ;  // unmapped index, write dropped
			endcase
		end
	end

	// stage 1 moves on when the output register is free or being emptied
	assign advance    = valid_s1 && (!result_valid || result_ready);
	assign item_ready = !valid_s1 || advance;
	assign item_xfer  = item_valid && item_ready;
	assign load_xfer  = item_xfer && (item.opcode == OP_LOAD);
	assign pixel_xfer = item_xfer && (item.opcode == OP_PIXEL);

	assign color_idx = item.pixel_byte[7:4];
	assign op_code4  = item.pixel_byte[3:0];
	assign slot_hit  = {1'b0, item.palette_slot} < 5'(PALETTE_ENTRIES);
	assign idx_hit   = {1'b0, color_idx} < 5'(PALETTE_ENTRIES);

	// percent from the table; scaling by 100 in plain mode keeps one divide path
	assign pct      = OPACITY_PCT[op_code4];
	assign disp_sat = (disp_opacity_q > OPACITY_FULL) ? OPACITY_FULL : disp_opacity_q;
	assign scale    = opacity_mode_q ? disp_sat : OPACITY_FULL;

	// palette memory: loads write, pixels read; a load is written at its transfer
	// edge, before any later pixel reads, so no forwarding is needed
	pspe_palette_ram #(
		.DEPTH(PALETTE_ENTRIES),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (load_xfer && slot_hit),
		.waddr(item.palette_slot[AW-1:0]),
		.wdata(item.palette_color),
		.re   (pixel_xfer && idx_hit),
		.raddr(color_idx[AW-1:0]),
		.rdata(ram_rdata)
	);

	pspe_scan u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (pixel_xfer),
		.sprite_width (sprite_width_q),
		.sprite_height(sprite_height_q),
		.origin_x     (origin_x_q),
		.origin_y     (origin_y_q),
		.pos          (pos)
	);

	// stage 1: coordinates, flags and opacity product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= pixel_xfer;
		end
	end

	always_ff @(posedge clk) begin
		if (pixel_xfer) begin
			x_s1    <= pos.x;
			y_s1    <= pos.y;
			last_s1 <= pos.last;
			hit_s1  <= idx_hit;
			prod_s1 <= 14'(pct * scale);
		end
	end

	// divide by 100 through the reciprocal
	assign recip_prod = 26'(prod_s1 * DIV100_RECIP);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result.pixel_x       <= x_s1;
			result.pixel_y       <= y_s1;
			result.pixel_color   <= hit_s1 ? ram_rdata : 16'd0;
			result.pixel_opacity <= recip_prod[DIV100_SHIFT +: 7];
			result.last_pixel    <= last_s1;
		end
	end

	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		load_xfer |=> !valid_s1)
		else $error("load item entered the pixel pipeline");

	a_pixel_enters: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_xfer |=> valid_s1)
		else $error("pixel transfer lost before stage 1");

	a_opacity_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.pixel_opacity <= OPACITY_FULL))
		else $error("pixel opacity above full scale");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && result_valid && !result_ready) |=> (valid_s1 && $stable(prod_s1)))
		else $error("stage 1 changed under a stalled result");

endmodule

`default_nettype wire

[tb/tb_palette_sprite_pixel_expander.sv]
// tb_palette_sprite_pixel_expander: self-checking bench for the palette sprite pixel expander
// drives palette loads, pixel bytes and register writes, predicts every pixel write command
// depends on pspe_pkg and palette_sprite_pixel_expander

module tb_palette_sprite_pixel_expander;
	import pspe_pkg::*;

	localparam int PAL_SIZE     = 16;
	localparam int DRAIN_CYCLES = 6;           // pipeline drain plus margin
	localparam int RUN_LIMIT    = 3_000_000;   // time units, far above the slowest run
	localparam int PHASE_ITEMS  = 70;
	localparam int IN_W         = $bits(pspe_in_t);

	// dut ports, every input known from time zero
	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  item_valid   = 1'b0;
	logic                  item_ready;
	pspe_in_t              item         = '0;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	pspe_out_t             result;
	logic                  cfg_valid    = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;

	// idle odds in percent, per item on the sender and per cycle on the receiver
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int mismatch_count = 0;

	// shadow of the block: palette, scan counters and registers
	logic [15:0] pal_shadow [PAL_SIZE];
	logic [7:0]  col_pos  = '0;
	logic [7:0]  row_pos  = '0;
	logic [15:0] org_x    = '0;
	logic [15:0] org_y    = '0;
	logic [7:0]  spr_w    = 8'd1;
	logic [7:0]  spr_h    = 8'd1;
	logic        opa_mode = 1'b0;
	logic [6:0]  disp_opa = OPACITY_FULL;

	// pixel writes predicted but not yet seen, oldest first
	pspe_out_t pending_pixels [$];

	always #5 clk = ~clk;

	palette_sprite_pixel_expander #(
		.PALETTE_ENTRIES(PAL_SIZE)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// receiver backpressure, one decision per cycle
	always @(posedge clk) begin
		result_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	function automatic void check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatch_count++;
		end
	endfunction

	// every result transfer is matched against the oldest predicted pixel
	always @(posedge clk) begin : check_results
		pspe_out_t want;
		if (result_valid === 1'b1 && result_ready) begin
			if (pending_pixels.size() == 0) begin
				$display("%0t: unexpected pixel write, expected none, actual %0h", $time, result);
				mismatch_count++;
			end else begin
				want = pending_pixels.pop_front();
				check_field("pixel_x", want.pixel_x, result.pixel_x);
				check_field("pixel_y", want.pixel_y, result.pixel_y);
				check_field("pixel_color", want.pixel_color, result.pixel_color);
				check_field("pixel_opacity", want.pixel_opacity, result.pixel_opacity);
				check_field("last_pixel", want.last_pixel, result.last_pixel);
			end
		end
	end

	// one pixel byte through the shadow: color lookup, opacity scaling, scan walk
	function automatic pspe_out_t expand_pixel(input logic [7:0] pbyte);
		pspe_out_t px;
		int w, h, pct, disp;
		bit end_col, end_row;
		// a zero size register behaves as one
		w = (spr_w == 0) ? 1 : int'(spr_w);
		h = (spr_h == 0) ? 1 : int'(spr_h);
		pct = int'(pbyte[3:0]) * 100 / 15;
		if (opa_mode) begin
			// display opacity saturates at full before scaling
			disp = (disp_opa > OPACITY_FULL) ? 100 : int'(disp_opa);
			pct = pct * disp / 100;
		end
		// a counter at or past the edge after a shrink counts as the edge
		end_col = (int'(col_pos) + 1 >= w);
		end_row = (int'(row_pos) + 1 >= h);
		px.pixel_x = org_x + col_pos;
		px.pixel_y = org_y + row_pos;
		px.pixel_color = (int'(pbyte[7:4]) < PAL_SIZE) ? pal_shadow[pbyte[7:4]] : 16'h0000;
		px.pixel_opacity = pct[6:0];
		px.last_pixel = end_col && end_row;
		if (end_col) begin
			col_pos = '0;
			row_pos = end_row ? 8'd0 : row_pos + 8'd1;
		end else begin
			col_pos = col_pos + 8'd1;
		end
		return px;
	endfunction

	// one item transfer; valid stays high afterwards so back-to-back items need no toggle
	task automatic send_item(input pspe_in_t it);
		if ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (item_ready !== 1'b1);
		if (it.opcode == OP_LOAD) begin
			// loads past the palette are dropped
			if (int'(it.palette_slot) < PAL_SIZE)
				pal_shadow[it.palette_slot] = it.palette_color;
		end else begin
			pending_pixels.push_back(expand_pixel(it.pixel_byte));
		end
	endtask

	// pixel item, the unused load fields carry noise
	task automatic send_pixel(input logic [7:0] pbyte);
		pspe_in_t it;
		it = IN_W'($urandom());
		it.opcode = OP_PIXEL;
		it.pixel_byte = pbyte;
		send_item(it);
	endtask

	task automatic send_load(input logic [3:0] slot, input logic [15:0] color);
		pspe_in_t it;
		it = IN_W'($urandom());
		it.opcode = OP_LOAD;
		it.palette_slot = slot;
		it.palette_color = color;
		send_item(it);
	endtask

	// stop items, let every predicted pixel arrive and the pipeline empty
	task automatic wait_idle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// one register write transfer, shadow updated with the field widths applied
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_ORIGIN_X:     org_x = data;
			CFG_ORIGIN_Y:     org_y = data;
			CFG_SPRITE_W:     spr_w = data[7:0];
			CFG_SPRITE_H:     spr_h = data[7:0];
			CFG_OPACITY_MODE: opa_mode = data[0];
			CFG_DISP_OPACITY: disp_opa = data[6:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// fill every palette entry, extremes at the ends, then read both corners
	task automatic test_palette_load();
		for (int slot = 0; slot < PAL_SIZE; slot++) begin
			if (slot == 0)
				send_load(slot[3:0], 16'h0000);
			else if (slot == PAL_SIZE - 1)
				send_load(slot[3:0], 16'hFFFF);
			else
				send_load(slot[3:0], 16'($urandom()));
		end
		// reset geometry is one by one, so each pixel is the last
		send_pixel(8'h00);
		send_pixel(8'hFF);
		wait_idle();
	endtask

	// display opacity scaling: saturation above full, zero, and mode off again
	task automatic test_opacity_scaling();
		write_reg(CFG_OPACITY_MODE, 16'h0001);
		write_reg(CFG_DISP_OPACITY, 16'h007F);
		send_pixel(8'h3F);
		send_pixel(8'hA7);
		wait_idle();
		write_reg(CFG_DISP_OPACITY, 16'h0000);
		send_pixel(8'h5F);
		wait_idle();
		write_reg(CFG_OPACITY_MODE, 16'h0000);
		write_reg(CFG_DISP_OPACITY, 16'(OPACITY_FULL));
	endtask

	// full 3x2 sprite, x origin wraps through the signed maximum, y starts at the signed minimum
	task automatic test_geometry_walk();
		write_reg(CFG_ORIGIN_X, 16'h7FFE);
		write_reg(CFG_ORIGIN_Y, 16'h8000);
		write_reg(CFG_SPRITE_W, 16'd3);
		write_reg(CFG_SPRITE_H, 16'd2);
		repeat (6) send_pixel(8'($urandom()));
		wait_idle();
	endtask

	// shrink the sprite mid-row, then zero sizes that act as one
	task automatic test_resize_mid_sprite();
		write_reg(CFG_ORIGIN_X, 16'h0000);
		write_reg(CFG_ORIGIN_Y, 16'h0000);
		write_reg(CFG_SPRITE_W, 16'd4);
		write_reg(CFG_SPRITE_H, 16'd3);
		repeat (3) send_pixel(8'($urandom()));
		wait_idle();
		// column counter now sits past the new last column
		write_reg(CFG_SPRITE_W, 16'd2);
		send_pixel(8'($urandom()));
		wait_idle();
		write_reg(CFG_SPRITE_W, 16'd0);
		write_reg(CFG_SPRITE_H, 16'd0);
		send_pixel(8'($urandom()));
		wait_idle();
	endtask

	// random register set, extremes weighted in, noise in unused data bits
	task automatic randomize_config();
		logic [15:0] d;
		case ($urandom_range(3))
			0: write_reg(CFG_ORIGIN_X, 16'h8000);
			1: write_reg(CFG_ORIGIN_X, 16'h7FFF);
			default: write_reg(CFG_ORIGIN_X, 16'($urandom()));
		endcase
		case ($urandom_range(3))
			0: write_reg(CFG_ORIGIN_Y, 16'h8000);
			1: write_reg(CFG_ORIGIN_Y, 16'h7FFF);
			default: write_reg(CFG_ORIGIN_Y, 16'($urandom()));
		endcase
		for (int r = 0; r < 2; r++) begin
			d = 16'($urandom());
			// mostly small sprites so the last pixel comes around often
			case ($urandom_range(7))
				0: d[7:0] = 8'd0;
				1: d[7:0] = 8'd255;
				2: d[7:0] = 8'($urandom_range(255, 1));
				default: d[7:0] = 8'($urandom_range(8, 1));
			endcase
			write_reg((r == 0) ? CFG_SPRITE_W : CFG_SPRITE_H, d);
		end
		write_reg(CFG_OPACITY_MODE, 16'($urandom()));
		d = 16'($urandom());
		case ($urandom_range(3))
			0: d[6:0] = 7'd0;
			1: d[6:0] = OPACITY_FULL;
			2: d[6:0] = 7'd127;
			default: d[6:0] = 7'($urandom_range(127));
		endcase
		write_reg(CFG_DISP_OPACITY, d);
	endtask

	// mixed loads and pixels under each idle pattern, new registers per phase
	task automatic test_random_traffic();
		pspe_in_t it;
		for (int s = 0; s < 3; s++) begin
			case (s)
				0: begin send_idle_pct = 38; recv_stall_pct = 86; end
				1: begin send_idle_pct = 86; recv_stall_pct = 38; end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			for (int ph = 0; ph < 6; ph++) begin
				randomize_config();
				repeat (PHASE_ITEMS) begin
					it = IN_W'($urandom());
					it.opcode = ($urandom_range(99) < 15) ? OP_LOAD : OP_PIXEL;
					send_item(it);
				end
				wait_idle();
			end
		end
	endtask

	initial begin
		send_idle_pct = 38;
		recv_stall_pct = 86;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_palette_load();
		test_opacity_scaling();
		test_geometry_walk();
		test_resize_mid_sprite();
		test_random_traffic();

		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// hang guard
	initial begin
		#(RUN_LIMIT);
		$display("DONE: errors detected");
		$finish;
	end

endmodule
